FILE: rtl/occupancy_grid_rect_marker_assert.svh
// Assertion macros shared by the occupancy grid RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef OCCUPANCY_GRID_RECT_MARKER_ASSERT_SVH
`define OCCUPANCY_GRID_RECT_MARKER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define OGRM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define OGRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ogrm_pkg.sv
// Shared types and constants of the occupancy grid rectangle marker.
// No dependencies; used by ogrm_div and occupancy_grid_rect_marker.
package ogrm_pkg;

   // default grid bounds
   localparam int MAX_COLS_DEF = 64;
   localparam int MAX_ROWS_DEF = 64;

   // width of effective row/column counts (covers up to 1024 rows)
   localparam int CNT_W = 11;

   // divider operand widths: doubled (Q.5) coordinates over doubled cell size
   localparam int NUM_W = 17;
   localparam int DEN_W = 13;
   localparam int STEP_W = 5;

   // CSR map
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SIZE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS    = 3'd5;

   // CSR reset values (cell 10.0, margin 13.0, field 640.0 x 640.0)
   localparam logic [11:0] CELL_SIZE_RST    = 12'd160;
   localparam logic [11:0] MARGIN_RST       = 12'd208;
   localparam logic [15:0] FIELD_WIDTH_RST  = 16'd10240;
   localparam logic [15:0] FIELD_HEIGHT_RST = 16'd10240;
   localparam logic [6:0]  GRID_COLS_RST    = 7'd64;
   localparam logic [6:0]  GRID_ROWS_RST    = 7'd64;

   // operation codes
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [15:0] size_x;
      logic [15:0] size_y;
      logic [5:0]  query_row;
      logic [5:0]  query_col;
   } ogrm_req_type;

   typedef struct packed {
      logic occupied;
      logic out_of_range;
   } ogrm_rsp_type;

   // divider result back to the sequencer
   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quot;
   } ogrm_div_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_SPAN,
      ST_ROWS,
      ST_QUERY_RD,
      ST_DONE
   } ogrm_state_type;

endpackage

FILE: rtl/ogrm_div.sv
// Restoring divider, one quotient bit per cycle, for edge-to-cell conversion.
// Depends on ogrm_pkg.
module ogrm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ogrm_pkg::NUM_W-1:0]    numer,
   input  logic [ogrm_pkg::DEN_W-1:0]    denom,
   output ogrm_pkg::ogrm_div_rsp_type    result
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [ogrm_pkg::STEP_W-1:0]   cnt_ff, cnt_in;
   logic [ogrm_pkg::NUM_W-1:0]    quot_ff, quot_in;
   logic [ogrm_pkg::DEN_W-1:0]    rem_ff, rem_in;
   logic [ogrm_pkg::DEN_W-1:0]    den_ff, den_in;

   logic [ogrm_pkg::DEN_W:0]      shifted;
   logic [ogrm_pkg::DEN_W:0]      diff;
   logic                          fits;

   // one restoring step
   always_comb begin
      shifted = {rem_ff, quot_ff[ogrm_pkg::NUM_W-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
   end

   // next state
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      done_in = busy_ff && (cnt_ff == '0);
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = ogrm_pkg::STEP_W'(ogrm_pkg::NUM_W - 1);
         quot_in = numer;
         rem_in  = '0;
         den_in  = denom;
      end else if (busy_ff) begin
         quot_in = {quot_ff[ogrm_pkg::NUM_W-2:0], fits};
         rem_in  = fits ? diff[ogrm_pkg::DEN_W-1:0] : shifted[ogrm_pkg::DEN_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign result.done = done_ff;
   assign result.quot = quot_ff;

endmodule

FILE: rtl/occupancy_grid_rect_marker.sv
// Occupancy grid with inflated rectangular obstacles: top level.
// Depends on ogrm_pkg, ogrm_div and occupancy_grid_rect_marker_assert.svh.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | req_data  (ogrm_req_type)
//   rsp     | out       | rsp_valid / rsp_ready | rsp_data  (ogrm_rsp_type)
//   csr     | in        | csr_write_en          | csr_index, csr_wdata
//
// Add beat: four serial divisions (one shared divider, one quotient bit per
// cycle), a span step, then one row a cycle through the row memory's
// read-modify-write. Query beat: one memory read. Reset is followed by a
// clearing pass over all MAX_ROWS rows during which req_ready stays low.
// The result sits in an output register; a stalled rsp holds only the final
// hand-off.
module occupancy_grid_rect_marker #(
   parameter int MAX_COLS = ogrm_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = ogrm_pkg::MAX_ROWS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  ogrm_pkg::ogrm_req_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output ogrm_pkg::ogrm_rsp_type               rsp_data,
   input  logic                                 csr_write_en,
   input  logic [ogrm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ogrm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

`include "occupancy_grid_rect_marker_assert.svh"

   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int COL_W = $clog2(MAX_COLS);
   localparam int CW    = ogrm_pkg::CNT_W;
   localparam int NW    = ogrm_pkg::NUM_W;

   // configuration registers
   logic [11:0] cell_size_ff, margin_ff;
   logic [15:0] field_width_ff, field_height_ff;
   logic [6:0]  grid_cols_ff, grid_rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff    <= ogrm_pkg::CELL_SIZE_RST;
         margin_ff       <= ogrm_pkg::MARGIN_RST;
         field_width_ff  <= ogrm_pkg::FIELD_WIDTH_RST;
         field_height_ff <= ogrm_pkg::FIELD_HEIGHT_RST;
         grid_cols_ff    <= ogrm_pkg::GRID_COLS_RST;
         grid_rows_ff    <= ogrm_pkg::GRID_ROWS_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            ogrm_pkg::CSR_CELL_SIZE:    cell_size_ff    <= csr_wdata[11:0];
            ogrm_pkg::CSR_MARGIN:       margin_ff       <= csr_wdata[11:0];
            ogrm_pkg::CSR_FIELD_WIDTH:  field_width_ff  <= csr_wdata;
            ogrm_pkg::CSR_FIELD_HEIGHT: field_height_ff <= csr_wdata;
            ogrm_pkg::CSR_GRID_COLS:    grid_cols_ff    <= csr_wdata[6:0];
            ogrm_pkg::CSR_GRID_ROWS:    grid_rows_ff    <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // effective grid size and last index per axis
   logic [CW-1:0] rows_eff, cols_eff, row_lim, col_lim;
   logic [CW-1:0] grid_rows_w, grid_cols_w;

   always_comb begin
      grid_rows_w = CW'(grid_rows_ff);
      grid_cols_w = CW'(grid_cols_ff);
      if (grid_rows_w == '0) begin
         rows_eff = CW'(1);
      end else if (grid_rows_w > CW'(MAX_ROWS)) begin
         rows_eff = CW'(MAX_ROWS);
      end else begin
         rows_eff = grid_rows_w;
      end
      if (grid_cols_w == '0) begin
         cols_eff = CW'(1);
      end else if (grid_cols_w > CW'(MAX_COLS)) begin
         cols_eff = CW'(MAX_COLS);
      end else begin
         cols_eff = grid_cols_w;
      end
      row_lim = rows_eff - 1'b1;
      col_lim = cols_eff - 1'b1;
   end

   // sequencer state and datapath registers
   ogrm_pkg::ogrm_state_type state_ff, state_in;
   ogrm_pkg::ogrm_req_type   item_ff;
   ogrm_pkg::ogrm_rsp_type   rsp_data_ff, rsp_data_in;
   logic                     rsp_valid_ff;
   logic [1:0]               div_idx_ff;
   logic [NW-1:0]            quot_ff [4];
   logic [ROW_W-1:0]         clr_ff;
   logic [ROW_W-1:0]         row_ff, row_last_ff, wr_row_ff;
   logic [MAX_COLS-1:0]      mask_ff, mask_in;
   logic                     pend_ff;
   logic                     oor_ff, oor_in;

   // control strobes
   logic req_take, div_start, rsp_load, span_empty;
   logic mem_we, mem_re;
   logic [ROW_W-1:0]    mem_waddr, mem_raddr;
   logic [MAX_COLS-1:0] mem_wdata, mem_rdata_ff;
   ogrm_pkg::ogrm_div_rsp_type div_rsp;

   // divider operand: near or far edge of one axis, in doubled units
   logic [15:0]           axis_c, axis_s, axis_lim;
   logic [17:0]           pos2, grow2, lim2, far_sum, near_v, far_v;
   logic [NW-1:0]         numer;
   logic [ogrm_pkg::DEN_W-1:0] denom;
   logic [11:0]           cs_eff;

   always_comb begin
      axis_c   = div_idx_ff[1] ? item_ff.center_x : item_ff.center_y;
      axis_s   = div_idx_ff[1] ? item_ff.size_x   : item_ff.size_y;
      axis_lim = div_idx_ff[1] ? field_width_ff   : field_height_ff;
      pos2     = {1'b0, axis_c, 1'b0};
      grow2    = {2'b0, axis_s} + {5'b0, margin_ff, 1'b0};
      lim2     = {1'b0, axis_lim, 1'b0};
      far_sum  = pos2 + grow2;
      near_v   = (pos2 >= grow2) ? (pos2 - grow2) : '0;
      far_v    = (far_sum > lim2) ? lim2 : far_sum;
      numer    = div_idx_ff[0] ? far_v[NW-1:0] : near_v[NW-1:0];
      cs_eff   = (cell_size_ff == '0) ? 12'd1 : cell_size_ff;
      denom    = {cs_eff, 1'b0};
   end

   ogrm_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .numer  (numer),
      .denom  (denom),
      .result (div_rsp)
   );

   // span: clamp far indices, detect empty spans, build the column mask
   logic [NW-1:0] fy_c, fx_c;

   always_comb begin
      fy_c = (quot_ff[1] > NW'(row_lim)) ? NW'(row_lim) : quot_ff[1];
      fx_c = (quot_ff[3] > NW'(col_lim)) ? NW'(col_lim) : quot_ff[3];
      span_empty = (quot_ff[0] > fy_c) || (quot_ff[2] > fx_c);
      for (int i = 0; i < MAX_COLS; i++) begin
         mask_in[i] = (NW'(i) >= quot_ff[2]) && (NW'(i) <= fx_c);
      end
   end

   // query range check and result build
   always_comb begin
      oor_in = (CW'(item_ff.query_row) >= rows_eff) ||
               (CW'(item_ff.query_col) >= cols_eff);
      rsp_data_in.out_of_range = (item_ff.operation == ogrm_pkg::OP_QUERY) && oor_ff;
      rsp_data_in.occupied     = (item_ff.operation == ogrm_pkg::OP_QUERY) && !oor_ff &&
                                 mem_rdata_ff[COL_W'(item_ff.query_col)];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ogrm_pkg::ST_CLEAR: begin
            if (clr_ff == ROW_W'(MAX_ROWS - 1)) state_in = ogrm_pkg::ST_IDLE;
         end
         ogrm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.operation == ogrm_pkg::OP_QUERY) ?
                          ogrm_pkg::ST_QUERY_RD : ogrm_pkg::ST_DIV_START;
            end
         end
         ogrm_pkg::ST_DIV_START: state_in = ogrm_pkg::ST_DIV_WAIT;
         ogrm_pkg::ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = (div_idx_ff == 2'd3) ? ogrm_pkg::ST_SPAN : ogrm_pkg::ST_DIV_START;
            end
         end
         ogrm_pkg::ST_SPAN: begin
            state_in = span_empty ? ogrm_pkg::ST_DONE : ogrm_pkg::ST_ROWS;
         end
         ogrm_pkg::ST_ROWS: begin
            if (row_ff == row_last_ff) state_in = ogrm_pkg::ST_DONE;
         end
         ogrm_pkg::ST_QUERY_RD: state_in = ogrm_pkg::ST_DONE;
         ogrm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ogrm_pkg::ST_IDLE;
         end
         default: state_in = ogrm_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      mem_re    = 1'b0;
      mem_raddr = row_ff;
      case (state_ff)
         ogrm_pkg::ST_IDLE:      req_ready = 1'b1;
         ogrm_pkg::ST_DIV_START: div_start = 1'b1;
         ogrm_pkg::ST_ROWS:      mem_re = 1'b1;
         ogrm_pkg::ST_QUERY_RD: begin
            mem_re    = 1'b1;
            mem_raddr = ROW_W'(item_ff.query_row);
         end
         ogrm_pkg::ST_DONE:      rsp_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
      req_take = req_valid && req_ready;
   end

   // memory write port: clearing pass, else the pending row write-back
   always_comb begin
      if (state_ff == ogrm_pkg::ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = pend_ff;
         mem_waddr = wr_row_ff;
         mem_wdata = mem_rdata_ff | mask_ff;
      end
   end

   // row memory, one read and one write port, registered read data
   logic [MAX_COLS-1:0] occ_mem [MAX_ROWS];

   always_ff @(posedge clock) begin
      if (mem_we) occ_mem[mem_waddr] <= mem_wdata;
      if (mem_re) mem_rdata_ff <= occ_mem[mem_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ogrm_pkg::ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ogrm_pkg::ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         pend_ff <= (state_ff == ogrm_pkg::ST_ROWS);
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_take) begin
            div_idx_ff <= '0;
         end else if (state_ff == ogrm_pkg::ST_DIV_WAIT && div_rsp.done) begin
            div_idx_ff <= div_idx_ff + 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) item_ff <= req_data;
      if (state_ff == ogrm_pkg::ST_DIV_WAIT && div_rsp.done) begin
         quot_ff[div_idx_ff] <= div_rsp.quot;
      end
      if (state_ff == ogrm_pkg::ST_SPAN) begin
         row_ff      <= ROW_W'(quot_ff[0]);
         row_last_ff <= ROW_W'(fy_c);
         mask_ff     <= mask_in;
      end else if (state_ff == ogrm_pkg::ST_ROWS) begin
         row_ff <= row_ff + 1'b1;
      end
      wr_row_ff <= row_ff;
      if (state_ff == ogrm_pkg::ST_QUERY_RD) oor_ff <= oor_in;
      if (rsp_load) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `OGRM_ASSERT_SAME(a_rmw_no_overlap, clock, reset, mem_we && mem_re,
      mem_waddr != mem_raddr, "row write and read hit the same entry")
   `OGRM_ASSERT_SAME(a_wb_in_window, clock, reset, pend_ff,
      state_ff == ogrm_pkg::ST_ROWS || state_ff == ogrm_pkg::ST_DONE,
      "row write-back outside the marking window")
   `OGRM_ASSERT_SAME(a_div_done_expected, clock, reset, div_rsp.done,
      state_ff == ogrm_pkg::ST_DIV_WAIT, "divider finished with no waiting edge")
   `OGRM_ASSERT_SAME(a_row_in_span, clock, reset, state_ff == ogrm_pkg::ST_ROWS,
      row_ff <= row_last_ff, "row walk ran past the span")
   `OGRM_ASSERT_NEXT(a_add_rsp_clear, clock, reset,
      rsp_load && item_ff.operation == ogrm_pkg::OP_ADD,
      !rsp_data_ff.occupied && !rsp_data_ff.out_of_range, "add beat returned flags")

endmodule
